// ----- rtl/lr_table_parse_engine_assert.svh -----
// assertion macros for the parse engine
`ifndef LR_TABLE_PARSE_ENGINE_ASSERT_SVH
`define LR_TABLE_PARSE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define LRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define LRP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LRP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LRP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/lrp_pkg.sv -----
// types and constants shared by the parse engine modules
`default_nettype none
package lrp_pkg;
	localparam logic [2:0] REQ_LOAD_ACTION = 3'd0;
	localparam logic [2:0] REQ_LOAD_GOTO   = 3'd1;
	localparam logic [2:0] REQ_LOAD_RULE   = 3'd2;
	localparam logic [2:0] REQ_TOKEN       = 3'd3;
	localparam logic [2:0] REQ_RESTART     = 3'd4;

	localparam logic [2:0] ACT_SHIFT    = 3'd1;
	localparam logic [2:0] ACT_REDUCE   = 3'd2;
	localparam logic [2:0] ACT_ACCEPT   = 3'd3;
	localparam logic [2:0] ACT_CONFLICT = 3'd4;

	localparam logic [3:0] EV_LOADED   = 4'd0;
	localparam logic [3:0] EV_REDUCE   = 4'd1;
	localparam logic [3:0] EV_SHIFT    = 4'd2;
	localparam logic [3:0] EV_ACCEPT   = 4'd3;
	localparam logic [3:0] EV_NOACT    = 4'd4;
	localparam logic [3:0] EV_CONFLICT = 4'd5;
	localparam logic [3:0] EV_NOGOTO   = 4'd6;
	localparam logic [3:0] EV_UNDER    = 4'd7;
	localparam logic [3:0] EV_OVER     = 4'd8;
	localparam logic [3:0] EV_LIMIT    = 4'd9;
	localparam logic [3:0] EV_FINISHED = 4'd10;

	localparam logic [6:0] EOI_CODE = 7'd64;
	localparam int MAX_RESULTS = 64;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  prod;
		logic [7:0]  state;
		logic [6:0]  term;
		logic [15:0] pos;
		logic        last;
	} event_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ACT_RD, ST_ACT, ST_RULE, ST_EXP_RD, ST_EXP,
		ST_GOTO, ST_EMIT
	} fsm_t;
endpackage
`default_nettype wire

// ----- rtl/lr_table_parse_engine.sv -----
// top level of the table driven shift-reduce parse engine
// loads and restarts: event registered at the accepting edge, one request a cycle unless the output stalls
// a token is worked in turn as accept, action read and decide, its event registered in the output stage
// each reduction adds the rule, stack and goto reads in turn, then a fresh action read;
// an underflow adds the rule read and an emit step; one request is worked at a time and output stalls hold the engine
// after reset the tables are undefined, the stack holds state 0 (entry zero reads as 0)
`default_nettype none
`include "lr_table_parse_engine_assert.svh"
module lr_table_parse_engine
	import lrp_pkg::*;
#(
	parameter int NUM_STATES       = 256,
	parameter int NUM_TERMINALS    = 64,
	parameter int NUM_NONTERMINALS = 64,
	parameter int NUM_PRODUCTIONS  = 256,
	parameter int STACK_DEPTH      = 64,
	parameter int MAX_RHS          = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// req_type, row_index, column_index, entry_kind, entry_target, rhs_length,
	// lhs_symbol, token_terminal, end_of_input, zero fill
	input  wire logic [47:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// event_kind, production_index, parse_state, error_terminal, token_position, zero fill
	output logic [47:0]      m_tdata,
	output logic             m_tlast
);
	localparam int ACT_COLS = NUM_TERMINALS + 1;
	localparam int ACT_DEPTH = NUM_STATES * ACT_COLS;
	localparam int GOTO_DEPTH = NUM_STATES * NUM_NONTERMINALS;
	localparam int AAW = $clog2(ACT_DEPTH);
	localparam int GAW = $clog2(GOTO_DEPTH);
	localparam int RAW = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);

	// request fields
	logic [2:0] req_type;
	logic [7:0] row_index, entry_target;
	logic [6:0] column_index;
	logic [2:0] entry_kind;
	logic [3:0] rhs_length;
	logic [5:0] lhs_symbol, token_terminal;
	logic       end_of_input;
	assign req_type       = s_tdata[2:0];
	assign row_index      = s_tdata[10:3];
	assign column_index   = s_tdata[17:11];
	assign entry_kind     = s_tdata[20:18];
	assign entry_target   = s_tdata[28:21];
	assign rhs_length     = s_tdata[32:29];
	assign lhs_symbol     = s_tdata[38:33];
	assign token_terminal = s_tdata[44:39];
	assign end_of_input   = s_tdata[45];

	// memories
	logic [10:0] act_mem [ACT_DEPTH];
	logic [8:0]  goto_mem [GOTO_DEPTH];
	logic [9:0]  rule_mem [NUM_PRODUCTIONS];
	logic [7:0]  stack_mem [STACK_DEPTH];

	fsm_t state_q, state_d;
	logic [SPW-1:0] sp_q;
	logic [15:0]    shifted_q;
	logic           done_q;
	logic [7:0]     top_q;
	logic           eoi_q;
	logic [5:0]     tok_q;
	logic [6:0]     tcode_q;
	logic [5:0]     nred_q;
	logic [7:0]     prod_q;
	logic [3:0]     n_q;
	logic [5:0]     lhs_q;
	logic [7:0]     exp_q;

	logic [10:0] act_rd_q;
	logic [8:0]  goto_rd_q;
	logic [9:0]  rule_rd_q;
	logic [7:0]  stack_rd_q;

	logic       accept;
	logic       out_full;
	logic       push;
	event_t     ev_d, ev_o;

	assign s_tready = (state_q == ST_IDLE) && !out_full;
	assign accept   = s_tvalid && s_tready;

	// rhs clamp and address forms
	logic [3:0] rhs_clamped;
	assign rhs_clamped = (int'(rhs_length) > MAX_RHS) ? 4'(MAX_RHS) : rhs_length;

	logic act_ld_ok, goto_ld_ok, rule_ld_ok;
	assign act_ld_ok  = (int'(row_index) < NUM_STATES) && (int'(column_index) < ACT_COLS);
	assign goto_ld_ok = (int'(row_index) < NUM_STATES) &&
		(int'(column_index) < NUM_NONTERMINALS);
	assign rule_ld_ok = int'(row_index) < NUM_PRODUCTIONS;

	logic [AAW-1:0] act_wa, act_ra;
	logic [GAW-1:0] goto_wa, goto_ra;
	assign act_wa  = AAW'(row_index * ACT_COLS + column_index);
	assign goto_wa = GAW'(row_index * NUM_NONTERMINALS + column_index);
	logic [6:0] col_q;
	assign col_q   = eoi_q ? 7'(NUM_TERMINALS) : {1'b0, tok_q};
	assign act_ra  = AAW'(top_q * ACT_COLS + col_q);
	assign goto_ra = GAW'(exp_q * NUM_NONTERMINALS + lhs_q);

	// table writes
	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_LOAD_ACTION && act_ld_ok) begin
			act_mem[act_wa] <= {entry_kind, entry_target};
		end
		if (accept && req_type == REQ_LOAD_GOTO && goto_ld_ok) begin
			goto_mem[goto_wa] <= {entry_kind == 3'd1, entry_target};
		end
		if (accept && req_type == REQ_LOAD_RULE && rule_ld_ok) begin
			rule_mem[RAW'(row_index)] <= {rhs_clamped, lhs_symbol};
		end
	end

	// table reads, registered; the rule is fetched while the action is decided
	always_ff @(posedge clk) begin
		act_rd_q  <= act_mem[act_ra];
		goto_rd_q <= goto_mem[goto_ra];
		rule_rd_q <= rule_mem[RAW'((state_q == ST_ACT) ? atgt : prod_q)];
	end

	// derived action values
	logic       act_ok;
	logic [2:0] akind;
	logic [7:0] atgt;
	assign act_ok = (int'(top_q) < NUM_STATES) && (eoi_q || int'(tok_q) < NUM_TERMINALS);
	assign akind  = act_ok ? act_rd_q[10:8] : 3'd0;
	assign atgt   = act_rd_q[7:0];

	logic goto_ok, goto_valid;
	assign goto_ok    = (int'(exp_q) < NUM_STATES) && (int'(lhs_q) < NUM_NONTERMINALS);
	assign goto_valid = goto_ok && goto_rd_q[8];

	logic [SPW-1:0] nsp;
	assign nsp = sp_q - SPW'(n_q);

	// stack port: one write address and one read address a cycle
	logic           stk_we;
	logic [SAW-1:0] stk_wa, stk_ra;
	logic [7:0]     stk_wd;
	always_comb begin
		stk_we = 1'b0;
		stk_wa = SAW'(sp_q);
		stk_wd = atgt;
		if (state_q == ST_ACT && akind == ACT_SHIFT && int'(sp_q) < STACK_DEPTH && !out_full) begin
			stk_we = 1'b1;
		end else if (state_q == ST_GOTO && goto_valid && int'(nsp) < STACK_DEPTH) begin
			stk_we = 1'b1;
			stk_wa = SAW'(nsp);
			stk_wd = goto_rd_q[7:0];
		end
	end
	assign stk_ra = (state_q == ST_RULE) ? SAW'(sp_q - SPW'(1) - SPW'(rule_rd_q[9:6]))
		: SAW'(sp_q - SPW'(1));

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_wa] <= stk_wd;
		end
		stack_rd_q <= stack_mem[stk_ra];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req_type == REQ_TOKEN && !done_q) begin
					state_d = ST_ACT_RD;
				end
			end
			ST_ACT_RD: state_d = ST_ACT;
			ST_ACT: begin
				if (!out_full) begin
					if (akind == ACT_REDUCE && int'(atgt) < NUM_PRODUCTIONS &&
						int'(nred_q) < MAX_RESULTS - 1) begin
						state_d = ST_RULE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_RULE: state_d = (int'(rule_rd_q[9:6]) >= int'(sp_q)) ? ST_EMIT : ST_EXP_RD;
			ST_EXP_RD: state_d = ST_EXP;
			ST_EXP: state_d = ST_GOTO;
			ST_GOTO: begin
				if (!out_full) begin
					state_d = (goto_valid && int'(nsp) < STACK_DEPTH) ? ST_ACT_RD : ST_IDLE;
				end
			end
			ST_EMIT: if (!out_full) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// event formation
	always_comb begin
		push = 1'b0;
		ev_d = '{kind: EV_LOADED, prod: 8'd0, state: 8'd0, term: 7'd0,
			pos: shifted_q, last: 1'b1};
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_LOAD_ACTION, REQ_LOAD_GOTO, REQ_LOAD_RULE: push = 1'b1;
						REQ_RESTART: begin
							push = 1'b1;
							ev_d.pos = 16'd0;
						end
						REQ_TOKEN: begin
							if (done_q) begin
								push = 1'b1;
								ev_d.kind = EV_FINISHED;
								ev_d.state = top_q;
							end
						end
						default: push = 1'b0;
					endcase
				end
			end
			ST_ACT: begin
				push = !out_full;
				ev_d.state = top_q;
				ev_d.term = tcode_q;
				if (akind == ACT_SHIFT) begin
					if (int'(sp_q) >= STACK_DEPTH) begin
						ev_d.kind = EV_OVER;
					end else begin
						ev_d.kind = EV_SHIFT;
						ev_d.state = atgt;
						ev_d.term = 7'd0;
						ev_d.pos = (shifted_q == 16'hFFFF) ? shifted_q : shifted_q + 16'd1;
					end
				end else if (akind == ACT_REDUCE && int'(atgt) < NUM_PRODUCTIONS) begin
					if (int'(nred_q) >= MAX_RESULTS - 1) begin
						ev_d.kind = EV_LIMIT;
					end else begin
						push = 1'b0;
					end
				end else if (akind == ACT_ACCEPT) begin
					ev_d.kind = EV_ACCEPT;
					ev_d.term = 7'd0;
				end else if (akind == ACT_CONFLICT) begin
					ev_d.kind = EV_CONFLICT;
				end else begin
					ev_d.kind = EV_NOACT;
				end
			end
			ST_GOTO: begin
				push = !out_full;
				ev_d.term = tcode_q;
				if (!goto_valid) begin
					ev_d.kind = EV_NOGOTO;
					ev_d.state = exp_q;
				end else if (int'(nsp) >= STACK_DEPTH) begin
					ev_d.kind = EV_OVER;
					ev_d.state = top_q;
				end else begin
					ev_d.kind = EV_REDUCE;
					ev_d.prod = prod_q;
					ev_d.state = goto_rd_q[7:0];
					ev_d.term = 7'd0;
					ev_d.last = 1'b0;
				end
			end
			ST_EMIT: begin
				push = !out_full;
				ev_d.kind = EV_UNDER;
				ev_d.state = top_q;
				ev_d.term = tcode_q;
			end
			default: push = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sp_q      <= SPW'(1);
			shifted_q <= 16'd0;
			done_q    <= 1'b0;
			top_q     <= 8'd0;
		end else begin
			state_q <= state_d;
			if (accept && req_type == REQ_RESTART) begin
				sp_q      <= SPW'(1);
				shifted_q <= 16'd0;
				done_q    <= 1'b0;
				top_q     <= 8'd0;
			end
			if (push && ev_d.last && ev_d.kind != EV_LOADED && ev_d.kind != EV_SHIFT &&
				ev_d.kind != EV_FINISHED) begin
				done_q <= 1'b1;
			end
			if (state_q == ST_ACT && push && ev_d.kind == EV_SHIFT) begin
				sp_q      <= sp_q + SPW'(1);
				shifted_q <= ev_d.pos;
				top_q     <= atgt;
			end
			if (state_q == ST_GOTO && push && ev_d.kind == EV_REDUCE) begin
				sp_q  <= nsp + SPW'(1);
				top_q <= goto_rd_q[7:0];
			end
		end
	end

	// token working registers; stack entry zero is never written and reads as state 0
	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_TOKEN) begin
			eoi_q   <= end_of_input;
			tok_q   <= token_terminal;
			tcode_q <= end_of_input ? EOI_CODE : {1'b0, token_terminal};
			nred_q  <= 6'd0;
		end
		if (state_q == ST_ACT) begin
			prod_q <= atgt;
		end
		if (state_q == ST_RULE) begin
			n_q   <= rule_rd_q[9:6];
			lhs_q <= rule_rd_q[5:0];
		end
		if (state_q == ST_EXP_RD) begin
			exp_q <= (sp_q == SPW'(n_q) + SPW'(1)) ? 8'd0 : stack_rd_q;
		end
		if (state_q == ST_GOTO && push && ev_d.kind == EV_REDUCE) begin
			nred_q <= nred_q + 6'd1;
		end
	end

	lrp_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.ev     (ev_d),
		.full   (out_full),
		.tvalid (m_tvalid),
		.tready (m_tready),
		.ev_out (ev_o)
	);

	assign m_tdata = {5'd0, ev_o.pos, ev_o.term, ev_o.state, ev_o.prod, ev_o.kind};
	assign m_tlast = ev_o.last;

	`LRP_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !s_tready)
	`LRP_ASSERT_IMP(a_sp_nonzero, clk, arst_n, 1'b1, sp_q != '0)
	`LRP_ASSERT_IMP(a_push_free, clk, arst_n, push, !out_full)
	`LRP_ASSERT_NXT(a_done_idle, clk, arst_n, push && ev_d.last, state_q == ST_IDLE)
endmodule
`default_nettype wire

// ----- rtl/lrp_out_reg.sv -----
// output register stage for result events
`default_nettype none
module lrp_out_reg
	import lrp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  event_t      ev,
	output logic        full,
	output logic        tvalid,
	input  wire logic   tready,
	output event_t      ev_out
);
	logic   valid_q;
	event_t ev_q;

	// one entry holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ev_q <= ev;
		end
	end

	assign full   = valid_q && !tready;
	assign tvalid = valid_q;
	assign ev_out = ev_q;
endmodule
`default_nettype wire

// ----- tb/sv/lr_table_parse_engine_test.sv -----
// self-checking testbench for the table driven shift-reduce parse engine
`default_nettype none
module lr_table_parse_engine_test;
	import lrp_pkg::*;

	localparam int ACT_COLS = 65;
	localparam int NT_COLS = 64;
	localparam int STACK_SIZE = 64;
	localparam int RHS_CAP = 8;
	localparam logic [6:0] EOI_COL = 7'd64;

	// which table entry a token would need before it is safe to send
	localparam int HOLE_NONE = 0;
	localparam int HOLE_ACTION = 1;
	localparam int HOLE_RULE = 2;
	localparam int HOLE_GOTO = 3;

	typedef struct {
		logic [2:0] req;
		logic [7:0] row;
		logic [6:0] col;
		logic [2:0] kind;
		logic [7:0] tgt;
		logic [3:0] rhs;
		logic [5:0] lhs;
		logic [5:0] term;
		logic       eoi;
	} request_t;

	typedef struct {
		request_t rq;
		bit       typed;
		event_t   ev;
	} dir_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// req_type, row_index, column_index, entry_kind, entry_target, rhs_length,
	// lhs_symbol, token_terminal, end_of_input, zero fill
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// event_kind, production_index, parse_state, error_terminal, token_position, zero fill
	logic [47:0] m_tdata;
	logic        m_tlast;

	lr_table_parse_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// shadow tables, with a flag per entry so that no unwritten entry is read
	logic [10:0] act_mem [ACT_COLS*256];
	bit          act_known [ACT_COLS*256];
	logic [8:0]  goto_mem [NT_COLS*256];
	bit          goto_known [NT_COLS*256];
	logic [9:0]  rule_mem [256];
	bit          rule_known [256];
	logic [7:0]  stack_mem [STACK_SIZE];
	int          depth;
	int          shifted;
	bit          ended;

	event_t expected_events[$];
	int     errors = 0;
	bit     calm = 1'b0;
	int     sink_hold = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#50000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic event_t make_event(logic [3:0] kind, logic [7:0] prod,
			logic [7:0] st, logic [6:0] term, int pos, logic last);
		event_t e;
		e.kind = kind;
		e.prod = prod;
		e.state = st;
		e.term = term;
		e.pos = pos[15:0];
		e.last = last;
		return e;
	endfunction

	function automatic request_t make_request(logic [2:0] req, logic [7:0] row,
			logic [6:0] col, logic [2:0] kind, logic [7:0] tgt, logic [3:0] rhs,
			logic [5:0] lhs, logic [5:0] term, logic eoi);
		request_t r;
		r.req = req;
		r.row = row;
		r.col = col;
		r.kind = kind;
		r.tgt = tgt;
		r.rhs = rhs;
		r.lhs = lhs;
		r.term = term;
		r.eoi = eoi;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 25);
	endfunction

	// walk one token through the shadow tables; stops at the first unknown entry
	function automatic int token_walk(logic [5:0] term, logic eoi, bit commit,
			output int hole);
		logic [7:0]  stk [STACK_SIZE];
		int          sp, cnt, k, col, top, n, exposed, nsp;
		logic [6:0]  tcode;
		logic [10:0] a;
		logic [9:0]  r;
		logic [8:0]  g;
		bit          fin, going;
		event_t      outq[$];
		stk = stack_mem;
		sp = depth;
		cnt = shifted;
		fin = ended;
		hole = 0;
		k = 0;
		col = eoi ? ACT_COLS - 1 : term;
		tcode = eoi ? EOI_CODE : {1'b0, term};
		going = !fin;
		if (fin)
			outq.push_back(make_event(EV_FINISHED, 0, stk[sp-1], 0, cnt, 1));
		while (going) begin
			top = stk[sp-1];
			hole = top * ACT_COLS + col;
			if (!act_known[hole])
				return HOLE_ACTION;
			a = act_mem[hole];
			going = 1'b0;
			fin = 1'b1;
			case (a[10:8])
				ACT_SHIFT: begin
					fin = 1'b0;
					if (sp >= STACK_SIZE) begin
						outq.push_back(make_event(EV_OVER, 0, top, tcode, cnt, 1));
						fin = 1'b1;
					end else begin
						stk[sp] = a[7:0];
						sp++;
						if (cnt < 65535)
							cnt++;
						outq.push_back(make_event(EV_SHIFT, 0, a[7:0], 0, cnt, 1));
					end
				end
				ACT_REDUCE: begin
					if (k >= MAX_RESULTS - 1) begin
						outq.push_back(make_event(EV_LIMIT, 0, top, tcode, cnt, 1));
					end else begin
						hole = a[7:0];
						if (!rule_known[hole])
							return HOLE_RULE;
						r = rule_mem[hole];
						n = r[9:6];
						if (n >= sp) begin
							outq.push_back(make_event(EV_UNDER, 0, top, tcode, cnt, 1));
						end else begin
							exposed = stk[sp-1-n];
							hole = exposed * NT_COLS + r[5:0];
							if (!goto_known[hole])
								return HOLE_GOTO;
							g = goto_mem[hole];
							nsp = sp - n;
							if (!g[8]) begin
								outq.push_back(make_event(EV_NOGOTO, 0, exposed, tcode, cnt, 1));
							end else if (nsp >= STACK_SIZE) begin
								outq.push_back(make_event(EV_OVER, 0, top, tcode, cnt, 1));
							end else begin
								stk[nsp] = g[7:0];
								sp = nsp + 1;
								outq.push_back(make_event(EV_REDUCE, a[7:0], g[7:0], 0, cnt, 0));
								k++;
								fin = 1'b0;
								going = 1'b1;
							end
						end
					end
				end
				ACT_ACCEPT:
					outq.push_back(make_event(EV_ACCEPT, 0, top, 0, cnt, 1));
				ACT_CONFLICT:
					outq.push_back(make_event(EV_CONFLICT, 0, top, tcode, cnt, 1));
				default:
					outq.push_back(make_event(EV_NOACT, 0, top, tcode, cnt, 1));
			endcase
		end
		hole = 0;
		if (commit) begin
			stack_mem = stk;
			depth = sp;
			shifted = cnt;
			ended = fin;
			foreach (outq[i])
				expected_events.push_back(outq[i]);
		end
		return HOLE_NONE;
	endfunction

	function automatic void restart_parse();
		foreach (stack_mem[i])
			stack_mem[i] = '0;
		depth = 1;
		shifted = 0;
		ended = 1'b0;
	endfunction

	// update the shadow state for one request and queue what it should emit
	function automatic void predict_request(request_t r);
		int hole;
		logic [3:0] rhs;
		case (r.req)
			REQ_LOAD_ACTION:
				if (r.col < ACT_COLS) begin
					act_mem[r.row * ACT_COLS + r.col] = {r.kind, r.tgt};
					act_known[r.row * ACT_COLS + r.col] = 1'b1;
				end
			REQ_LOAD_GOTO:
				if (r.col < NT_COLS) begin
					goto_mem[r.row * NT_COLS + r.col] = {r.kind == 3'd1, r.tgt};
					goto_known[r.row * NT_COLS + r.col] = 1'b1;
				end
			REQ_LOAD_RULE: begin
				rhs = (r.rhs > RHS_CAP) ? 4'(RHS_CAP) : r.rhs;
				rule_mem[r.row] = {rhs, r.lhs};
				rule_known[r.row] = 1'b1;
			end
			REQ_TOKEN: begin
				void'(token_walk(r.term, r.eoi, 1'b1, hole));
				return;
			end
			REQ_RESTART:
				restart_parse();
			default:
				return;
		endcase
		expected_events.push_back(make_event(EV_LOADED, 0, 0, 0, shifted, 1));
	endfunction

	// predict, then hand the request over once the engine takes it
	task automatic issue(request_t r, bit typed = 1'b0, event_t ev = '0);
		int gap;
		predict_request(r);
		if (typed) begin
			void'(expected_events.pop_back());
			expected_events.push_back(ev);
		end
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, r.eoi, r.term, r.lhs, r.rhs, r.tgt, r.kind, r.col, r.row, r.req};
		do @(posedge clk); while (!s_tready);
	endtask

	// random contents for a table entry that a token is about to need
	function automatic request_t fill_request(int need, int hole);
		int w;
		logic [2:0] kind;
		w = $urandom_range(0, 99);
		case (need)
			HOLE_ACTION: begin
				if (w < 45) kind = ACT_SHIFT;
				else if (w < 82) kind = ACT_REDUCE;
				else if (w < 88) kind = ACT_ACCEPT;
				else if (w < 92) kind = ACT_CONFLICT;
				else kind = 3'($urandom_range(0, 7));
				return make_request(REQ_LOAD_ACTION, hole / ACT_COLS, hole % ACT_COLS, kind,
					(kind == ACT_REDUCE) ? $urandom_range(0, 15) :
					(w % 10 == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7),
					$urandom, $urandom, $urandom, $urandom);
			end
			HOLE_RULE:
				return make_request(REQ_LOAD_RULE, hole, $urandom, $urandom, $urandom,
					(w < 90) ? $urandom_range(0, 3) : $urandom_range(0, 15),
					$urandom_range(0, 7), $urandom, $urandom);
			default:
				return make_request(REQ_LOAD_GOTO, hole / NT_COLS, hole % NT_COLS,
					(w < 90) ? 3'd1 : 3'($urandom_range(0, 7)),
					(w % 10 == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7),
					$urandom, $urandom, $urandom, $urandom);
		endcase
	endfunction

	// load whatever the token would read for the first time, then send it
	task automatic send_token(logic [5:0] term, logic eoi);
		int need, hole;
		forever begin
			need = token_walk(term, eoi, 1'b0, hole);
			if (need == HOLE_NONE)
				break;
			issue(fill_request(need, hole));
		end
		issue(make_request(REQ_TOKEN, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, term, eoi));
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	// event sink with random stalls
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			sink_hold <= pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each event with the oldest prediction
	always @(posedge clk) begin
		event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_events.size() == 0) begin
				report_mismatch("unexpected event kind", m_tdata[3:0], 0);
			end else begin
				want = expected_events.pop_front();
				if (m_tdata[3:0] !== want.kind)
					report_mismatch("event_kind", m_tdata[3:0], want.kind);
				if (m_tdata[11:4] !== want.prod)
					report_mismatch("production_index", m_tdata[11:4], want.prod);
				if (m_tdata[19:12] !== want.state)
					report_mismatch("parse_state", m_tdata[19:12], want.state);
				if (m_tdata[26:20] !== want.term)
					report_mismatch("error_terminal", m_tdata[26:20], want.term);
				if (m_tdata[42:27] !== want.pos)
					report_mismatch("token_position", m_tdata[42:27], want.pos);
				if (m_tlast !== want.last)
					report_mismatch("last", m_tlast, want.last);
			end
		end
	end

	// stimulus
	initial begin
		dir_row_t rows[$];
		dir_row_t d;
		int w;
		restart_parse();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed: small grammar reaching each way a parse can end but stack overflow
		d.typed = 1'b1;
		d.ev = make_event(EV_LOADED, 0, 0, 0, 0, 1);
		d.rq = make_request(REQ_LOAD_ACTION, 0, 0, ACT_SHIFT, 1, 0, 0, 0, 0); rows.push_back(d);
		d.rq = make_request(REQ_LOAD_ACTION, 0, 127, 3'd7, 255, 15, 63, 63, 1); rows.push_back(d);
		d.rq = make_request(REQ_LOAD_ACTION, 1, EOI_COL, ACT_REDUCE, 0, 0, 0, 0, 0); rows.push_back(d);
		d.rq = make_request(REQ_LOAD_ACTION, 1, 2, ACT_ACCEPT, 0, 0, 0, 0, 0); rows.push_back(d);
		d.rq = make_request(REQ_LOAD_ACTION, 1, 3, ACT_CONFLICT, 0, 0, 0, 0, 0); rows.push_back(d);
		d.rq = make_request(REQ_LOAD_ACTION, 1, 4, 3'd7, 0, 0, 0, 0, 0); rows.push_back(d);
		d.rq = make_request(REQ_LOAD_ACTION, 1, 5, ACT_REDUCE, 255, 0, 0, 0, 0); rows.push_back(d);
		d.rq = make_request(REQ_LOAD_ACTION, 1, 6, ACT_REDUCE, 1, 0, 0, 0, 0); rows.push_back(d);
		d.rq = make_request(REQ_LOAD_RULE, 0, 0, 0, 0, 1, 5, 0, 0); rows.push_back(d);
		d.rq = make_request(REQ_LOAD_RULE, 255, 0, 0, 0, 15, 63, 0, 0); rows.push_back(d);
		d.rq = make_request(REQ_LOAD_RULE, 1, 0, 0, 0, 0, 9, 0, 0); rows.push_back(d);
		d.rq = make_request(REQ_LOAD_GOTO, 0, 5, 3'd1, 1, 0, 0, 0, 0); rows.push_back(d);
		d.rq = make_request(REQ_LOAD_GOTO, 1, 9, 3'd0, 1, 0, 0, 0, 0); rows.push_back(d);
		d.rq = make_request(REQ_LOAD_GOTO, 0, 64, 3'd1, 255, 0, 0, 0, 0); rows.push_back(d);
		d.typed = 1'b0;
		d.rq = make_request(3'd7, 255, 127, 7, 255, 15, 63, 63, 1); rows.push_back(d);
		// shift, accept, then a token after the end
		d.rq = make_request(REQ_TOKEN, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(d);
		d.typed = 1'b1;
		d.ev = make_event(EV_ACCEPT, 0, 1, 0, 1, 1);
		d.rq = make_request(REQ_TOKEN, 0, 0, 0, 0, 0, 0, 2, 0); rows.push_back(d);
		d.ev = make_event(EV_FINISHED, 0, 1, 0, 1, 1); rows.push_back(d);
		// conflict, no action, underflow and missing goto, each after a restart
		for (int t = 3; t <= 6; t++) begin
			d.typed = 1'b1;
			d.ev = make_event(EV_LOADED, 0, 0, 0, 0, 1);
			d.rq = make_request(REQ_RESTART, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(d);
			d.typed = 1'b0;
			d.rq = make_request(REQ_TOKEN, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(d);
			d.typed = 1'b1;
			d.ev = make_event((t == 3) ? EV_CONFLICT : (t == 4) ? EV_NOACT :
				(t == 5) ? EV_UNDER : EV_NOGOTO, 0, 1, 7'(t), 1, 1);
			d.rq = make_request(REQ_TOKEN, 0, 0, 0, 0, 0, 0, 6'(t), 0); rows.push_back(d);
		end
		// endless unit reduction on end of input runs into the reduce limit
		d.typed = 1'b1;
		d.ev = make_event(EV_LOADED, 0, 0, 0, 0, 1);
		d.rq = make_request(REQ_RESTART, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(d);
		d.typed = 1'b0;
		d.rq = make_request(REQ_TOKEN, 0, 0, 0, 0, 0, 0, 0, 0); rows.push_back(d);
		d.rq = make_request(REQ_TOKEN, 0, 0, 0, 0, 0, 0, 0, 1); rows.push_back(d);
		foreach (rows[i])
			issue(rows[i].rq, rows[i].typed, rows[i].ev);

		// stack overflow through repeated shifts
		issue(make_request(REQ_RESTART, 0, 0, 0, 0, 0, 0, 0, 0));
		issue(make_request(REQ_LOAD_ACTION, 0, 7, ACT_SHIFT, 2, 0, 0, 0, 0));
		issue(make_request(REQ_LOAD_ACTION, 2, 7, ACT_SHIFT, 2, 0, 0, 0, 0));
		repeat (STACK_SIZE) send_token(7, 0);

		// random: mostly parses over a growing random grammar, some loads and noise
		for (int i = 0; i < 70; i++) begin
			calm = (i >= 30 && i < 45);
			w = $urandom_range(0, 99);
			if (ended && w < 70)
				issue(make_request(REQ_RESTART, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom));
			else if (w < 8)
				issue(make_request(REQ_LOAD_ACTION, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom));
			else if (w < 12)
				issue(make_request(REQ_LOAD_GOTO, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom));
			else if (w < 15)
				issue(make_request(REQ_LOAD_RULE, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom));
			else if (w < 18)
				issue(make_request(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom));
			else if (w < 21)
				issue(make_request(REQ_RESTART, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom));
			else if (w < 31)
				send_token($urandom, 1'b1);
			else if (w < 43)
				send_token($urandom_range(0, 63), 1'b0);
			else
				send_token($urandom_range(0, 7), 1'b0);
		end
		calm = 1'b0;

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (expected_events.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
